[rtl/core/mcpr_pkg.sv]
// motor command packet receiver: shared types and constants
// no dependencies; imported by the receiver top level and its checker
package mcpr_pkg;

	// store of the bytes that carry commands
	localparam int STORE_DEPTH = 14;
	localparam int IDX_W       = 4;
	localparam int MOTOR_COUNT = 10;

	// configuration register indexes
	localparam logic [1:0] CFG_HEADER_FIRST  = 2'd0;
	localparam logic [1:0] CFG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] CFG_MAX_RPM       = 2'd2;

	localparam logic [7:0]  HEADER_FIRST_RST  = 8'd170;
	localparam logic [7:0]  HEADER_SECOND_RST = 8'd85;
	localparam logic [15:0] MAX_RPM_RST       = 16'd10000;

	// result kinds
	localparam logic [1:0] KIND_SPEED = 2'd0;
	localparam logic [1:0] KIND_PULSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// crc-8, msb first
	localparam logic [7:0] CRC_POLY = 8'h07;

	// speed mapping
	localparam logic [7:0] SPEED_LOW  = 8'd100;
	localparam logic [7:0] SPEED_MID  = 8'd150;
	localparam logic [7:0] SPEED_HIGH = 8'd200;

	// divide by 50 as multiply by ceil(2^28 / 50), exact for products below 2^22
	localparam int          RECIP_SHIFT = 28;
	localparam int          PROD_W      = 22;
	localparam int          RECIP_W     = 23;
	localparam logic [22:0] RECIP_K     = 23'd5368710;

	localparam logic [11:0] PULSE_MAX = 12'd2550;

endpackage

[rtl/core/motor_command_packet_receiver_top.sv]
// motor command packet receiver: header hunt, crc-8 check, command output
// depends on mcpr_pkg
//
//   channel   direction   handshake             payload
//   cfg       in          cfg_wr_en             cfg_index, cfg_data
//   in        in          in_valid / in_stall   rx_byte
//   out       out         out_valid / out_stall kind, channel, speed, pulse_width, last,
//                                               good_packets, bad_packets
//
// header and crc bytes are taken in idle; a data byte then runs ST_CRC, one crc bit a cycle
// a good crc byte walks the 14 stored bytes: a skipped motor byte steps on, a speed runs
// ST_MUL1 and ST_MUL2 (two multiplies via the shared reciprocal divider), then ST_EMIT;
// each speed or pulse result but the last waits out any output stall; reset is asynchronous,
// the stored bytes are not reset; a packet's final result may wait in the output register
// while later bytes are taken; only the next crc byte is held off until it drains
module motor_command_packet_receiver_top
	import mcpr_pkg::*;
#(
	parameter int DATA_BYTES = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [3:0]         channel,
	output logic signed [16:0] speed,
	output logic [11:0]        pulse_width,
	output logic               last,
	output logic [31:0]        good_packets,
	output logic [31:0]        bad_packets
);

	localparam int POS_W = $clog2(DATA_BYTES + 1);
	localparam logic [POS_W-1:0] POS_CRC = POS_W'(DATA_BYTES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CRC  = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_MUL2 = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;
	localparam logic [2:0] ST_WAIT = 3'd6;

	logic [2:0]       state_q;
	logic [7:0]       hdr_first_q;
	logic [7:0]       hdr_second_q;
	logic [15:0]      max_rpm_q;
	logic             collecting_q;
	logic             saw_first_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       crc_q;
	logic [2:0]       bit_cnt_q;
	logic [IDX_W-1:0] idx_q;
	logic [31:0]      good_q;
	logic [31:0]      bad_q;
	logic             out_valid_q;

	logic [7:0]       store_q [STORE_DEPTH];
	logic [5:0]       diff_q;
	logic             neg_q;
	logic [PROD_W-1:0] prod_s1;
	logic [15:0]      quot_s2;

	logic [1:0]       kind_q;
	logic [3:0]       channel_q;
	logic [16:0]      speed_q;
	logic [11:0]      pw_q;
	logic             last_q;

	logic             in_acc;
	logic             out_acc;
	logic             is_crc_byte;
	logic             crc_ok;
	logic [7:0]       rd_byte;
	logic             in_range;
	logic             idx_motor;
	logic             idx_final;
	logic [PROD_W+RECIP_W-1:0] recip_prod;
	logic [11:0]      pw_calc;

	assign is_crc_byte = collecting_q && (pos_q == POS_CRC);
	// the crc byte is held off while the previous packet's final result is pending
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && is_crc_byte);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign crc_ok    = (rx_byte == crc_q);

	assign rd_byte   = store_q[idx_q];
	assign in_range  = (rd_byte >= SPEED_LOW) && (rd_byte <= SPEED_HIGH);
	assign idx_motor = (idx_q < IDX_W'(MOTOR_COUNT));
	assign idx_final = (idx_q == IDX_W'(STORE_DEPTH - 1));
	assign recip_prod = (PROD_W + RECIP_W)'(prod_s1) * (PROD_W + RECIP_W)'(RECIP_K);
	assign pw_calc   = ({4'b0, rd_byte} << 3) + ({4'b0, rd_byte} << 1);

	// control path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			hdr_first_q  <= HEADER_FIRST_RST;
			hdr_second_q <= HEADER_SECOND_RST;
			max_rpm_q    <= MAX_RPM_RST;
			collecting_q <= 1'b0;
			saw_first_q  <= 1'b0;
			pos_q        <= '0;
			crc_q        <= '0;
			bit_cnt_q    <= '0;
			idx_q        <= '0;
			good_q       <= '0;
			bad_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_HEADER_FIRST:  hdr_first_q  <= cfg_data[7:0];
					CFG_HEADER_SECOND: hdr_second_q <= cfg_data[7:0];
					CFG_MAX_RPM:       max_rpm_q    <= cfg_data;
					default: ;
				endcase
			end

			if (out_acc) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!collecting_q) begin
							if (saw_first_q && rx_byte == hdr_second_q) begin
								collecting_q <= 1'b1;
								saw_first_q  <= 1'b0;
								pos_q        <= '0;
								crc_q        <= '0;
							end else begin
								saw_first_q <= (rx_byte == hdr_first_q);
							end
						end else if (!is_crc_byte) begin
							crc_q     <= crc_q ^ rx_byte;
							bit_cnt_q <= '0;
							pos_q     <= pos_q + 1'b1;
							state_q   <= ST_CRC;
						end else begin
							collecting_q <= 1'b0;
							saw_first_q  <= 1'b0;
							pos_q        <= '0;
							if (!crc_ok) begin
								bad_q       <= bad_q + 32'd1;
								out_valid_q <= 1'b1;
							end else begin
								good_q  <= good_q + 32'd1;
								idx_q   <= '0;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_CRC: begin
					// one bit of the crc division per cycle
					crc_q     <= crc_q[7] ? ({crc_q[6:0], 1'b0} ^ CRC_POLY)
					                      : {crc_q[6:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == 3'd7) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (idx_motor) begin
						if (in_range) begin
							state_q <= ST_MUL1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						out_valid_q <= 1'b1;
						state_q     <= idx_final ? ST_IDLE : ST_WAIT;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_EMIT;
				ST_EMIT: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_acc) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// byte store, only the first entries of a packet are kept
	always_ff @(posedge clk) begin
		if (in_acc && collecting_q && !is_crc_byte && pos_q < POS_W'(STORE_DEPTH)) begin
			store_q[pos_q[IDX_W-1:0]] <= rx_byte;
		end
	end

	// shared speed datapath and output register
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && idx_motor) begin
			neg_q  <= (rd_byte < SPEED_MID);
			diff_q <= (rd_byte < SPEED_MID) ? 6'(SPEED_MID - rd_byte) : 6'(rd_byte - SPEED_MID);
		end
		if (state_q == ST_MUL1) begin
			prod_s1 <= PROD_W'(diff_q) * PROD_W'(max_rpm_q);
		end
		if (state_q == ST_MUL2) begin
			quot_s2 <= recip_prod[RECIP_SHIFT +: 16];
		end

		if (state_q == ST_IDLE && in_acc && is_crc_byte && !crc_ok) begin
			kind_q    <= KIND_ERROR;
			channel_q <= '0;
			speed_q   <= '0;
			pw_q      <= '0;
			last_q    <= 1'b1;
		end else if (state_q == ST_SCAN && !idx_motor) begin
			kind_q    <= KIND_PULSE;
			channel_q <= idx_q - IDX_W'(MOTOR_COUNT);
			speed_q   <= '0;
			pw_q      <= pw_calc;
			last_q    <= idx_final;
		end else if (state_q == ST_EMIT) begin
			kind_q    <= KIND_SPEED;
			channel_q <= idx_q;
			speed_q   <= neg_q ? (17'd0 - {1'b0, quot_s2}) : {1'b0, quot_s2};
			pw_q      <= '0;
			last_q    <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign channel      = channel_q;
	assign speed        = signed'(speed_q);
	assign pulse_width  = pw_q;
	assign last         = last_q;
	assign good_packets = good_q;
	assign bad_packets  = bad_q;

endmodule

[rtl/core/mcpr_checker.sv]
// port-level checks for the motor command packet receiver, with its bind
// depends on mcpr_pkg and motor_command_packet_receiver_top
module mcpr_checker
	import mcpr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         kind,
	input logic [3:0]         channel,
	input logic signed [16:0] speed,
	input logic [11:0]        pulse_width,
	input logic               last,
	input logic [31:0]        good_packets,
	input logic [31:0]        bad_packets
);

	// a stalled result transaction stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(kind) && $stable(channel)
			&& $stable(speed) && $stable(pulse_width) && $stable(last))
		else $error("stalled result changed");

	// a checksum error is a lone result with empty fields
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ERROR |-> last && channel == 4'd0 && speed == 17'sd0
			&& pulse_width == 12'd0)
		else $error("malformed checksum error result");

	// pulse widths use the four pulse channels and never carry a speed
	a_pulse_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_PULSE |-> channel < 4'd4 && speed == 17'sd0
			&& pulse_width <= PULSE_MAX)
		else $error("malformed pulse width result");

	// packet counters step by one and never both in the same cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && (good_packets != $past(good_packets)
			|| bad_packets != $past(bad_packets)) |->
		(good_packets == $past(good_packets) + 32'd1 && bad_packets == $past(bad_packets))
		|| (bad_packets == $past(bad_packets) + 32'd1 && good_packets == $past(good_packets)))
		else $error("packet counter jumped");

endmodule

bind motor_command_packet_receiver_top mcpr_checker u_mcpr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.kind         (kind),
	.channel      (channel),
	.speed        (speed),
	.pulse_width  (pulse_width),
	.last         (last),
	.good_packets (good_packets),
	.bad_packets  (bad_packets)
);
